// ===== rtl/gf13mi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf13mi_pkg: shared types, microcode and packing for the GF(2^13) unit
// Field element widths, the packed word format, the datapath operand select
// codes and the read-only microprogram that drives the shared multiplier.
// ----------------------------------------------------------------------------
package gf13mi_pkg;

   localparam int FIELD_W   = 13;
   localparam int WORD_W    = 29;
   localparam int LOW_COEFS = 8;
   localparam int PC_W      = 5;
   localparam int PROD_W    = 2 * FIELD_W - 1;

   // modulus x^13 + x^4 + x^3 + x + 1 without the leading term
   localparam logic [FIELD_W-1:0] POLY_LOW = 13'h001B;

   typedef logic [FIELD_W-1:0] elem_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [PC_W-1:0]    pc_type;

   // program entry points
   localparam pc_type PC_MUL_ENTRY = 5'd0;
   localparam pc_type PC_INV_ENTRY = 5'd1;

   typedef enum logic {
      X_SRC_A,
      X_SRC_ACC
   } x_src_type;

   typedef enum logic [2:0] {
      Y_SRC_A,
      Y_SRC_B,
      Y_SRC_ACC,
      Y_SRC_CUBE,
      Y_SRC_FIFTH
   } y_src_type;

   typedef struct packed {
      x_src_type x_src;
      y_src_type y_src;
      logic      save_cube;
      logic      save_fifth;
      logic      last;
   } ctrl_word_type;

   // microprogram: multiply at entry 0, inversion chain from entry 1
   function automatic ctrl_word_type ucode_rom(input pc_type addr);
      ctrl_word_type cw;
      cw = '{x_src: X_SRC_ACC, y_src: Y_SRC_ACC, save_cube: 1'b0,
             save_fifth: 1'b0, last: 1'b0};
      unique case (addr)
         5'd0:  begin
            cw.x_src = X_SRC_A;
            cw.y_src = Y_SRC_B;
            cw.last  = 1'b1;
         end
         // a^2
         5'd1:  begin
            cw.x_src = X_SRC_A;
            cw.y_src = Y_SRC_A;
         end
         // a^3
         5'd2:  begin
            cw.y_src     = Y_SRC_A;
            cw.save_cube = 1'b1;
         end
         5'd3, 5'd4: ;
         // a^15
         5'd5:  begin
            cw.y_src      = Y_SRC_CUBE;
            cw.save_fifth = 1'b1;
         end
         5'd6, 5'd7, 5'd8, 5'd9: ;
         // a^255
         5'd10: cw.y_src = Y_SRC_FIFTH;
         5'd11, 5'd12, 5'd13, 5'd14: ;
         // a^4095
         5'd15: cw.y_src = Y_SRC_FIFTH;
         // final squaring gives a^8190
         5'd16: cw.last = 1'b1;
         default: cw.last = 1'b1;
      endcase
      return cw;
   endfunction

   // packed word to field element
   function automatic elem_type unpack13(input word_type w);
      elem_type v;
      for (int i = 0; i < LOW_COEFS; i++) begin
         v[i] = w[4*i];
      end
      for (int i = LOW_COEFS; i < FIELD_W; i++) begin
         v[i] = w[4*(i-LOW_COEFS)+1];
      end
      return v;
   endfunction

   // field element to canonical packed word
   function automatic word_type pack13(input elem_type v);
      word_type w;
      w = '0;
      for (int i = 0; i < LOW_COEFS; i++) begin
         w[4*i] = v[i];
      end
      for (int i = LOW_COEFS; i < FIELD_W; i++) begin
         w[4*(i-LOW_COEFS)+1] = v[i];
      end
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/gf2_13_multiply_inverse_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf2_13_multiply_inverse_unit_core: GF(2^13) multiply and invert unit
// Microcoded sequencer around one shared field multiplier.
// ----------------------------------------------------------------------------
// A request transfers on a rising edge with start high and busy low. It
// carries req_op (0 multiply, 1 invert), req_operand_a and req_operand_b in
// the packed radix-16 coefficient format; bits outside the thirteen
// coefficient positions are ignored, and operand b is ignored for inversion.
// The response appears on rsp_result for exactly one cycle with rsp_valid
// high and always transfers; the receiver has no way to stall it.
// Each request runs a short program from a read-only table, one control
// word per cycle through the single multiplier: a multiply takes one step,
// an inversion takes sixteen (twelve squarings and four multiplications).
// busy is high from the cycle after the request until the last step; the
// response is valid in the cycle after the last step, while the next
// request may already transfer. Inverting zero returns zero.
// Synchronous reset clears busy and the response strobe; no clearing pass.
// ----------------------------------------------------------------------------
module gf2_13_multiply_inverse_unit_core
   import gf13mi_pkg::*;
(
   input  wire            clock,
   input  wire            reset,
   input  wire            start,
   output logic           busy,
   input  wire            req_op,
   input  wire word_type  req_operand_a,
   input  wire word_type  req_operand_b,
   output logic           rsp_valid,
   output word_type       rsp_result
);

   logic          busy_ff,       busy_in;
   pc_type        pc_ff,         pc_in;
   elem_type      a_ff,          a_in;
   elem_type      b_ff,          b_in;
   elem_type      acc_ff,        acc_in;
   elem_type      cube_ff,       cube_in;
   elem_type      fifth_ff,      fifth_in;
   logic          rsp_valid_ff,  rsp_valid_in;
   word_type      rsp_result_ff, rsp_result_in;

   ctrl_word_type cw;
   elem_type      mul_x;
   elem_type      mul_y;
   elem_type      mul_p;
   logic          accept;

   // current control word
   assign cw     = ucode_rom(pc_ff);
   assign accept = start && !busy_ff;

   // operand selection
   always_comb begin
      unique case (cw.x_src)
         X_SRC_A:   mul_x = a_ff;
         X_SRC_ACC: mul_x = acc_ff;
         default:   mul_x = '0;
      endcase
   end

   always_comb begin
      unique case (cw.y_src)
         Y_SRC_A:     mul_y = a_ff;
         Y_SRC_B:     mul_y = b_ff;
         Y_SRC_ACC:   mul_y = acc_ff;
         Y_SRC_CUBE:  mul_y = cube_ff;
         Y_SRC_FIFTH: mul_y = fifth_ff;
         default:     mul_y = '0;
      endcase
   end

   gf13mi_mul u_mul (
      .mul_x (mul_x),
      .mul_y (mul_y),
      .mul_p (mul_p)
   );

   // sequencer and datapath next values
   always_comb begin
      busy_in       = busy_ff;
      pc_in         = pc_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      acc_in        = acc_ff;
      cube_in       = cube_ff;
      fifth_in      = fifth_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      if (busy_ff) begin
         acc_in = mul_p;
         if (cw.save_cube) begin
            cube_in = mul_p;
         end
         if (cw.save_fifth) begin
            fifth_in = mul_p;
         end
         if (cw.last) begin
            busy_in       = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_result_in = pack13(mul_p);
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end else if (accept) begin
         busy_in = 1'b1;
         a_in    = unpack13(req_operand_a);
         b_in    = unpack13(req_operand_b);
         pc_in   = req_op ? PC_INV_ENTRY : PC_MUL_ENTRY;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= PC_MUL_ENTRY;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      acc_ff        <= acc_in;
      cube_ff       <= cube_in;
      fifth_ff      <= fifth_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule
`default_nettype wire

// ===== rtl/gf13mi_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf13mi_mul: combinational GF(2^13) multiplier
// Carry-less 13 by 13 product followed by a two-fold reduction against
// the sparse modulus x^13 + x^4 + x^3 + x + 1.
// ----------------------------------------------------------------------------
module gf13mi_mul
   import gf13mi_pkg::*;
(
   input  wire elem_type mul_x,
   input  wire elem_type mul_y,
   output elem_type      mul_p
);

   localparam int HI_W   = PROD_W - FIELD_W;
   localparam int FOLD_W = FIELD_W + 3;

   logic [PROD_W-1:0] prod;
   logic [HI_W-1:0]   hi;
   logic [FOLD_W-1:0] fold;
   logic [2:0]        hi2;

   // partial products xored together
   always_comb begin
      prod = '0;
      for (int i = 0; i < FIELD_W; i++) begin
         if (mul_y[i]) begin
            prod = prod ^ ({{(PROD_W-FIELD_W){1'b0}}, mul_x} << i);
         end
      end
   end

   // first fold: x^13 = x^4 + x^3 + x + 1
   always_comb begin
      hi   = prod[PROD_W-1:FIELD_W];
      fold = {{(FOLD_W-FIELD_W){1'b0}}, prod[FIELD_W-1:0]}
           ^ {{(FOLD_W-HI_W){1'b0}}, hi}
           ^ ({{(FOLD_W-HI_W){1'b0}}, hi} << 1)
           ^ ({{(FOLD_W-HI_W){1'b0}}, hi} << 3)
           ^ ({{(FOLD_W-HI_W){1'b0}}, hi} << 4);
   end

   // second fold of the three bits left above the field
   always_comb begin
      hi2   = fold[FOLD_W-1:FIELD_W];
      mul_p = fold[FIELD_W-1:0]
            ^ {{(FIELD_W-3){1'b0}}, hi2}
            ^ ({{(FIELD_W-3){1'b0}}, hi2} << 1)
            ^ ({{(FIELD_W-3){1'b0}}, hi2} << 3)
            ^ ({{(FIELD_W-3){1'b0}}, hi2} << 4);
   end

endmodule
`default_nettype wire
